// File: rtl/mdfr_pkg.sv
`timescale 1ns / 1ps

package mdfr_pkg;

    // Source table geometry.
    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // Header fields.
    localparam int ID_W   = 16;
    localparam int SEQ_W  = 13;
    localparam int HOP_W  = 3;
    localparam int WORD_W = HOP_W + SEQ_W;
    localparam int ENTRY_W = ID_W + SEQ_W;

    // Sequence number rules.
    localparam logic [SEQ_W-1:0]        RESTART_SEQ_MAX = SEQ_W'(5);
    localparam logic signed [SEQ_W-1:0] RESTART_DIFF    = -SEQ_W'(10);

    // Register file.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOPS = 1'b1;
    localparam logic [ID_W-1:0]      OWN_ID_RESET   = 16'hFFFF;
    localparam logic [HOP_W-1:0]     MAX_HOPS_RESET = 3'd4;

    // Stream widths.
    localparam int S_DATA_W = 2 * ID_W;
    localparam int M_DATA_W = 24;

    typedef enum logic [2:0] {
        V_HOP_LIMIT = 3'd0,
        V_DUPLICATE = 3'd1,
        V_OWN       = 3'd2,
        V_FULL      = 3'd3,
        V_ADVANCED  = 3'd4,
        V_RESTART   = 3'd5,
        V_NEW       = 3'd6
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

endpackage

// File: rtl/mesh_duplicate_filter_relay.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// s_*      in         s_tvalid / s_tready    s_tdata: source_id, hop_seq_word
// m_*      out        m_tvalid / m_tready    m_tdata: verdict, deliver, relay, relay_hop_seq_word
// cfg_*    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One header word is handled at a time. A word rejected by the hop limit or the own id
// check goes from acceptance through ST_FINISH to the output register. Any other word
// scans the table one entry per cycle through the memory's single read port, stopping
// at a match or after the last entry. The input reopens in the cycle after the result
// enters the output register, even if it still waits on m_tready; the next result then
// holds until the output register frees. Reset clears the valid flip-flops.

module mesh_duplicate_filter_relay (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] source_id, [31:16] hop_seq_word
    input  logic [mdfr_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] verdict, [3] deliver, [4] relay, [20:5] relay_hop_seq_word, [23:21] zero
    output logic [mdfr_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mdfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mdfr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mdfr_pkg::*;

    // Configuration registers.
    logic [ID_W-1:0]  own_id_reg;
    logic [HOP_W-1:0] max_hops_reg;

    // Control state.
    state_t                   state_reg, state_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                     cmp_valid_reg, cmp_valid_next;
    logic                     free_found_reg, free_found_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic                     m_valid_reg, m_valid_next;

    // Payload held for the word being worked on.
    logic [ID_W-1:0]     src_reg, src_next;
    logic [SEQ_W-1:0]    seq_reg, seq_next;
    logic [HOP_W-1:0]    hops_reg, hops_next;
    verdict_t            verdict_reg, verdict_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    // Source table: source id above the last sequence number.
    logic [ENTRY_W-1:0] entry_mem [TABLE_ENTRIES];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    // Input fields.
    logic [ID_W-1:0]   in_src;
    logic [WORD_W-1:0] in_word;
    logic [HOP_W-1:0]  in_hops;

    // Compare stage.
    logic                    entry_ok;
    logic                    cmp_hit;
    logic                    cmp_free;
    logic                    cmp_last;
    logic [SEQ_W-1:0]        diff;
    logic                    seq_advance;
    logic                    seq_restart;
    logic [IDX_W-1:0]        new_idx;

    // Result fields.
    logic              res_deliver;
    logic              res_relay;
    logic [HOP_W:0]    hops_inc;
    logic [WORD_W-1:0] res_word;
    logic              out_free;

    assign in_src   = s_tdata[ID_W-1:0];
    assign in_word  = s_tdata[S_DATA_W-1:ID_W];
    assign in_hops  = in_word[WORD_W-1:SEQ_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_free  = !m_valid_reg || m_tready;

    // The configuration must only be written while the block is idle; the block itself does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg   <= OWN_ID_RESET;
            max_hops_reg <= MAX_HOPS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OWN_ID:   own_id_reg   <= cfg_data[ID_W-1:0];
                CFG_MAX_HOPS: max_hops_reg <= cfg_data[HOP_W-1:0];
                default:      ;
            endcase
        end
    end

    // Table memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= entry_mem[rd_idx_reg];
    end

    // The entry read last cycle is compared here. Memory contents only count for a
    // valid entry, since unwritten rows hold whatever came up at power on.
    assign entry_ok = cmp_valid_reg && valid_reg[cmp_idx_reg];
    assign cmp_hit  = entry_ok && (rd_data_reg[ENTRY_W-1:SEQ_W] == src_reg);
    assign cmp_free = cmp_valid_reg && !valid_reg[cmp_idx_reg];
    assign cmp_last = cmp_valid_reg && (cmp_idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign new_idx  = free_found_reg ? free_idx_reg : cmp_idx_reg;

    // Serial-number distance, modulo 2^13, read as a signed value.
    assign diff        = seq_reg - rd_data_reg[SEQ_W-1:0];
    assign seq_advance = (diff != '0) && !diff[SEQ_W-1];
    assign seq_restart = (seq_reg <= RESTART_SEQ_MAX) && ($signed(diff) < RESTART_DIFF);

    // The relay word carries the hop count plus one. max_hops is at most 7, so the
    // incremented count still fits the field whenever relaying is allowed.
    assign res_deliver = verdict_reg inside {V_ADVANCED, V_RESTART, V_NEW};
    assign hops_inc    = {1'b0, hops_reg} + (HOP_W + 1)'(1);
    assign res_relay   = res_deliver && (hops_inc < {1'b0, max_hops_reg});
    assign res_word    = res_relay ? {hops_inc[HOP_W-1:0], seq_reg} : '0;

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        m_valid_next    = m_valid_reg;
        src_next        = src_reg;
        seq_next        = seq_reg;
        hops_next       = hops_reg;
        verdict_next    = verdict_reg;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = cmp_idx_reg;
        mem_wdata       = {src_reg, seq_reg};

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    src_next        = in_src;
                    seq_next        = in_word[SEQ_W-1:0];
                    hops_next       = in_hops;
                    rd_idx_next     = '0;
                    cmp_valid_next  = 1'b0;
                    free_found_next = 1'b0;
                    if (in_hops >= max_hops_reg)
                    begin
                        verdict_next = V_HOP_LIMIT;
                        state_next   = ST_FINISH;
                    end
                    else if (in_src == own_id_reg)
                    begin
                        verdict_next = V_OWN;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue the next read; the address parks on the last entry.
                cmp_valid_next = 1'b1;
                cmp_idx_next   = rd_idx_reg;
                if (rd_idx_reg != IDX_W'(TABLE_ENTRIES - 1))
                begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end

                if (cmp_free && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end

                if (cmp_hit)
                begin
                    mem_waddr  = cmp_idx_reg;
                    state_next = ST_FINISH;
                    if (seq_advance)
                    begin
                        mem_we       = 1'b1;
                        verdict_next = V_ADVANCED;
                    end
                    else if (seq_restart)
                    begin
                        mem_we       = 1'b1;
                        verdict_next = V_RESTART;
                    end
                    else
                    begin
                        verdict_next = V_DUPLICATE;
                    end
                end
                else if (cmp_last)
                begin
                    state_next = ST_FINISH;
                    if (free_found_reg || cmp_free)
                    begin
                        mem_we                = 1'b1;
                        mem_waddr             = new_idx;
                        valid_next[new_idx]   = 1'b1;
                        verdict_next          = V_NEW;
                    end
                    else
                    begin
                        verdict_next = V_FULL;
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(M_DATA_W - 5 - WORD_W)'(0), res_word, res_relay,
                                    res_deliver, verdict_reg};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            rd_idx_reg     <= '0;
            cmp_idx_reg    <= '0;
            cmp_valid_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            rd_idx_reg     <= rd_idx_next;
            cmp_idx_reg    <= cmp_idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        seq_reg     <= seq_next;
        hops_reg    <= hops_next;
        verdict_reg <= verdict_next;
        m_data_reg  <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    // Entries are only ever claimed, never released.
    a_valid_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) >= $past($countones(valid_reg))))
        else $error("table entry lost its valid bit");

    // At most one entry is claimed per word.
    a_one_claim: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) <= $past($countones(valid_reg)) + 1))
        else $error("more than one entry claimed");

    // A relayed word is always a delivered one.
    a_relay_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[4]) |-> m_data_reg[3])
        else $error("relay without deliver");

    // Delivery follows from the verdict alone.
    a_deliver_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_data_reg[3] == (m_data_reg[2:0] == V_ADVANCED ||
                                           m_data_reg[2:0] == V_RESTART ||
                                           m_data_reg[2:0] == V_NEW)))
        else $error("deliver flag disagrees with verdict");

    // The table is only written while a scan is under way.
    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_SCAN))
        else $error("table write outside a scan");
`endif

endmodule
